/* rtl/core/rational_fraction_alu_defines.svh */
// assertion macros shared by the rational fraction alu rtl
`ifndef RATIONAL_FRACTION_ALU_DEFINES_SVH
`define RATIONAL_FRACTION_ALU_DEFINES_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rfa_pkg.sv */
// shared types, widths and codes of the rational fraction alu
package rfa_pkg;

    // operand width and the field that carries it
    localparam int OPERAND_BITS = 16;
    localparam int FIELD_BITS   = 16;
    localparam int OP_W         = (OPERAND_BITS < FIELD_BITS) ? OPERAND_BITS : FIELD_BITS;

    // operand after sign fix, products, sums and magnitudes
    localparam int NORM_W      = OP_W + 1;
    localparam int PROD_W      = 2 * OP_W;
    localparam int SUM_W       = PROD_W + 1;
    localparam int MAG_W       = PROD_W;
    localparam int GCD_SHIFT_W = $clog2(MAG_W + 1);
    localparam int DIV_CNT_W   = $clog2(MAG_W);

    // result field widths
    localparam int OPC_W = 3;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;

    localparam logic [OPC_W-1:0] OP_ADD = 3'd0;
    localparam logic [OPC_W-1:0] OP_SUB = 3'd1;
    localparam logic [OPC_W-1:0] OP_MUL = 3'd2;
    localparam logic [OPC_W-1:0] OP_DIV = 3'd3;
    localparam logic [OPC_W-1:0] OP_CMP = 3'd4;

    typedef struct packed {
        logic [OPC_W-1:0]             operation;
        logic signed [FIELD_BITS-1:0] num_a;
        logic signed [FIELD_BITS-1:0] den_a;
        logic signed [FIELD_BITS-1:0] num_b;
        logic signed [FIELD_BITS-1:0] den_b;
    } in_item_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic [DEN_W-1:0]        res_den;
        logic                    is_less;
        logic                    is_equal;
        logic                    fault;
    } out_item_t;

    // which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_P0,
        MUL_P1,
        MUL_P2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     prep;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic fault;
        logic is_cmp;
        logic gcd_done;
        logic div_last;
    } dp_status_t;

endpackage

/* rtl/core/rational_fraction_alu.sv */
// top level of the rational fraction alu: controller, datapath and checks
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in      | into      | in_valid/in_stall  | in_data: operation, a and b
//  out     | out of    | out_valid/out_stall| out_data: reduced fraction, flags
//
//  one item at a time; an item passes capture, the three multiplies and the
//  combine, then for arithmetic prep, binary gcd (data dependent), a last gcd
//  state that loads the divider and the divide steps, then the output register
//  compare finishes after the combine cycle, a fault after the first multiply
//  the output register holds a finished result while the next item is taken
//  rst_n clears the sequencer and output valid; payload registers are not reset
//  a stalled output holds the result and only blocks the end of the next item
`include "rational_fraction_alu_defines.svh"

module rational_fraction_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rfa_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rfa_pkg::out_item_t out_data
);

    // command and status between sequencer and datapath
    rfa_pkg::dp_cmd_t    cmd;
    rfa_pkg::dp_status_t status;

    rfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // operands, shared multiplier, gcd and the two quotient shifters
    rfa_datapath u_datapath (
        .clk     (clk),
        .in_data (in_data),
        .cmd     (cmd),
        .status  (status),
        .result  (out_data)
    );

    // a fault result carries nothing else
    `RFA_ASSERT_SAME(a_fault_clean, out_valid && out_data.fault, (out_data.res_num == '0) && (out_data.res_den == '0) && !out_data.is_less && !out_data.is_equal, "fault result has nonzero fields")

    // an arithmetic result never carries compare flags or fault
    `RFA_ASSERT_SAME(a_den_only_arith, out_valid && (out_data.res_den != '0), !out_data.fault && !out_data.is_less && !out_data.is_equal, "arithmetic result with flags set")

    // compare flags exclude each other
    `RFA_ASSERT_SAME(a_flags_exclusive, out_valid, !(out_data.is_less && out_data.is_equal), "less and equal both set")

    // a transfer in makes the block busy on the next cycle
    `RFA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input taken twice in a row")

endmodule

/* rtl/core/rfa_ctrl.sv */
// sequencing state machine and output valid of the rational fraction alu
module rfa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  rfa_pkg::dp_status_t status,
    output rfa_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_PREP,
        S_GCD,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rfa_pkg::MUL_P0;
                state_next  = status.fault ? S_OUT : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rfa_pkg::MUL_P1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rfa_pkg::MUL_P2;
                state_next  = S_COMB;
            end
            S_COMB:
            begin
                cmd.combine = 1'b1;
                state_next  = status.is_cmp ? S_OUT : S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (status.gcd_done)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = S_DIV;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // output slot free now or freed by this cycle's transfer
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/rfa_datapath.sv */
// operand registers, shared multiplier, binary gcd and dual divider of the fraction alu
module rfa_datapath (
    input  logic                clk,
    input  rfa_pkg::in_item_t   in_data,
    input  rfa_pkg::dp_cmd_t    cmd,
    output rfa_pkg::dp_status_t status,
    output rfa_pkg::out_item_t  result
);

    localparam int NORM_W      = rfa_pkg::NORM_W;
    localparam int PROD_W      = rfa_pkg::PROD_W;
    localparam int SUM_W       = rfa_pkg::SUM_W;
    localparam int MAG_W       = rfa_pkg::MAG_W;
    localparam int OP_W        = rfa_pkg::OP_W;
    localparam int GCD_SHIFT_W = rfa_pkg::GCD_SHIFT_W;
    localparam int DIV_CNT_W   = rfa_pkg::DIV_CNT_W;

    logic [rfa_pkg::OPC_W-1:0] op_reg;
    logic                      fault_reg;
    logic signed [NORM_W-1:0]  na_reg, da_reg, nb_reg, db_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg;
    logic signed [SUM_W-1:0]   rn_reg, rd_reg;
    logic                      neg_reg;
    logic                      less_reg, equal_reg;
    logic [MAG_W-1:0]          u_reg, v_reg;
    logic [GCD_SHIFT_W-1:0]    k_reg;
    logic [MAG_W-1:0]          div_reg;
    logic [MAG_W-1:0]          qn_reg, qd_reg;
    logic [MAG_W-1:0]          remn_reg, remd_reg;
    logic [DIV_CNT_W-1:0]      cnt_reg;
    rfa_pkg::out_item_t        result_reg;

    logic signed [NORM_W-1:0]   na_in, da_in, nb_in, db_in;
    logic                       fault_in;
    logic signed [NORM_W-1:0]   mul_a, mul_b;
    logic signed [2*NORM_W-1:0] mul_full;
    logic signed [PROD_W-1:0]   mul_prod;
    logic signed [SUM_W-1:0]    p0_ext, p1_ext, p2_ext;
    logic signed [SUM_W-1:0]    rn_comb, rd_comb;
    logic signed [SUM_W-1:0]    rn_fix, rd_fix, rn_abs;
    logic [MAG_W:0]             remn_sh, remd_sh, div_ext;
    logic                       qn_bit, qd_bit;
    logic signed [SUM_W-1:0]    qn_signed;
    rfa_pkg::out_item_t         result_next;

    // operand capture: sign-extend, then make both denominators positive
    always_comb
    begin
        na_in = NORM_W'(signed'(in_data.num_a[OP_W-1:0]));
        da_in = NORM_W'(signed'(in_data.den_a[OP_W-1:0]));
        nb_in = NORM_W'(signed'(in_data.num_b[OP_W-1:0]));
        db_in = NORM_W'(signed'(in_data.den_b[OP_W-1:0]));
        fault_in = (da_in == '0) || (db_in == '0) || (in_data.operation > rfa_pkg::OP_CMP)
                   || ((in_data.operation == rfa_pkg::OP_DIV) && (nb_in == '0));
    end

    // shared multiplier, operand pair picked per step and operation
    always_comb
    begin
        unique case (cmd.mul_sel)
            rfa_pkg::MUL_P0:
            begin
                mul_a = na_reg;
                mul_b = (op_reg == rfa_pkg::OP_MUL) ? nb_reg : db_reg;
            end
            rfa_pkg::MUL_P1:
            begin
                mul_a = da_reg;
                mul_b = (op_reg == rfa_pkg::OP_MUL) ? db_reg : nb_reg;
            end
            default:
            begin
                mul_a = da_reg;
                mul_b = db_reg;
            end
        endcase
        mul_full = mul_a * mul_b;
        mul_prod = mul_full[PROD_W-1:0];
    end

    // cross-product combine
    always_comb
    begin
        p0_ext = SUM_W'(p0_reg);
        p1_ext = SUM_W'(p1_reg);
        p2_ext = SUM_W'(p2_reg);
        unique case (op_reg)
            rfa_pkg::OP_ADD:
            begin
                rn_comb = p0_ext + p1_ext;
                rd_comb = p2_ext;
            end
            rfa_pkg::OP_SUB:
            begin
                rn_comb = p0_ext - p1_ext;
                rd_comb = p2_ext;
            end
            default:
            begin
                rn_comb = p0_ext;
                rd_comb = p1_ext;
            end
        endcase
    end

    // positive denominator and numerator magnitude
    always_comb
    begin
        rn_fix = (rd_reg < 0) ? -rn_reg : rn_reg;
        rd_fix = (rd_reg < 0) ? -rd_reg : rd_reg;
        rn_abs = (rn_fix < 0) ? -rn_fix : rn_fix;
    end

    // one restoring step on both dividends against the common divisor
    always_comb
    begin
        div_ext = {1'b0, div_reg};
        remn_sh = {remn_reg, qn_reg[MAG_W-1]};
        remd_sh = {remd_reg, qd_reg[MAG_W-1]};
        qn_bit  = (remn_sh >= div_ext);
        qd_bit  = (remd_sh >= div_ext);
    end

    // result word
    always_comb
    begin
        result_next = '0;
        qn_signed   = signed'(SUM_W'(qn_reg));
        if (fault_reg)
        begin
            result_next.fault = 1'b1;
        end
        else if (op_reg == rfa_pkg::OP_CMP)
        begin
            result_next.is_less  = less_reg;
            result_next.is_equal = equal_reg;
        end
        else
        begin
            result_next.res_num = rfa_pkg::NUM_W'(neg_reg ? -qn_signed : qn_signed);
            result_next.res_den = rfa_pkg::DEN_W'(qd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_data.operation;
            fault_reg <= fault_in;
            na_reg    <= (da_in < 0) ? -na_in : na_in;
            da_reg    <= (da_in < 0) ? -da_in : da_in;
            nb_reg    <= (db_in < 0) ? -nb_in : nb_in;
            db_reg    <= (db_in < 0) ? -db_in : db_in;
        end

        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                rfa_pkg::MUL_P0: p0_reg <= mul_prod;
                rfa_pkg::MUL_P1: p1_reg <= mul_prod;
                default:         p2_reg <= mul_prod;
            endcase
        end

        if (cmd.combine)
        begin
            rn_reg    <= rn_comb;
            rd_reg    <= rd_comb;
            less_reg  <= (p0_reg < p1_reg);
            equal_reg <= (p0_reg == p1_reg);
        end

        if (cmd.prep)
        begin
            neg_reg <= (rn_fix < 0);
            qn_reg  <= MAG_W'(rn_abs);
            qd_reg  <= MAG_W'(rd_fix);
            u_reg   <= MAG_W'(rn_abs);
            v_reg   <= MAG_W'(rd_fix);
            k_reg   <= '0;
        end
        else if (cmd.gcd_step)
        begin
            // binary gcd: strip common twos, strip lone twos, subtract odds
            priority if (!u_reg[0] && !v_reg[0])
            begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end
            else if (!u_reg[0])
            begin
                u_reg <= u_reg >> 1;
            end
            else if (!v_reg[0])
            begin
                v_reg <= v_reg >> 1;
            end
            else if (u_reg >= v_reg)
            begin
                u_reg <= u_reg - v_reg;
            end
            else
            begin
                v_reg <= v_reg - u_reg;
            end
        end

        if (cmd.div_init)
        begin
            div_reg  <= v_reg << k_reg;
            remn_reg <= '0;
            remd_reg <= '0;
            cnt_reg  <= DIV_CNT_W'(MAG_W - 1);
        end
        else if (cmd.div_step)
        begin
            // remainder stays below the divisor, so the top bit drops out
            remn_reg <= MAG_W'(qn_bit ? (remn_sh - div_ext) : remn_sh);
            remd_reg <= MAG_W'(qd_bit ? (remd_sh - div_ext) : remd_sh);
            qn_reg   <= {qn_reg[MAG_W-2:0], qn_bit};
            qd_reg   <= {qd_reg[MAG_W-2:0], qd_bit};
            cnt_reg  <= cnt_reg - 1'b1;
        end

        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign status.fault    = fault_reg;
    assign status.is_cmp   = (op_reg == rfa_pkg::OP_CMP);
    assign status.gcd_done = (u_reg == '0);
    assign status.div_last = (cnt_reg == '0);
    assign result          = result_reg;

endmodule

/* sim/rfa_checker.sv */
// checker for the rational fraction alu: predicts each result and compares transfers
`timescale 1ns / 100ps

module rfa_checker
    import rfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_data,
    output int        err_count,
    output int        pending,
    output int        result_count,
    output int        fault_count,
    output int        cmp_count
);

    out_item_t awaited_results[$];

    // low OP_W bits of a field, sign-extended
    function automatic longint operand_of(input logic [FIELD_BITS-1:0] raw);
        longint v;
        v = longint'(raw[OP_W-1:0]);
        if (raw[OP_W-1])
        begin
            v = v - (longint'(1) <<< OP_W);
        end
        return v;
    endfunction

    function automatic out_item_t lowest_terms_result(input in_item_t item);
        out_item_t         r;
        longint            na;
        longint            da;
        longint            nb;
        longint            db;
        longint            rn;
        longint            rd;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   t;
        r  = '0;
        na = operand_of(item.num_a);
        da = operand_of(item.den_a);
        nb = operand_of(item.num_b);
        db = operand_of(item.den_b);
        if (da == 0 || db == 0 || item.operation > OP_CMP
            || (item.operation == OP_DIV && nb == 0))
        begin
            r.fault = 1'b1;
            return r;
        end
        if (da < 0)
        begin
            da = -da;
            na = -na;
        end
        if (db < 0)
        begin
            db = -db;
            nb = -nb;
        end
        if (item.operation == OP_CMP)
        begin
            r.is_less  = (na * db < nb * da);
            r.is_equal = (na * db == nb * da);
            return r;
        end
        case (item.operation)
            OP_ADD:
            begin
                rn = na * db + nb * da;
                rd = da * db;
            end
            OP_SUB:
            begin
                rn = na * db - nb * da;
                rd = da * db;
            end
            OP_MUL:
            begin
                rn = na * nb;
                rd = da * db;
            end
            default:
            begin
                rn = na * db;
                rd = da * nb;
            end
        endcase
        if (rd < 0)
        begin
            rd = -rd;
            rn = -rn;
        end
        // euclid on magnitudes, gcd is never zero as rd is positive
        x = (rn < 0) ? -rn : rn;
        y = rd;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        rn = rn / longint'(x);
        rd = rd / longint'(x);
        r.res_num = rn[NUM_W-1:0];
        r.res_den = rd[DEN_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    initial
    begin
        err_count    = 0;
        pending      = 0;
        result_count = 0;
        fault_count  = 0;
        cmp_count    = 0;
    end

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n)
        begin
            // retire before queueing: a result is never for the item taken at the same edge
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (awaited_results.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result with none awaited, expected nothing actual %p",
                             $time, out_data);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("res_num", want.res_num, out_data.res_num);
                    check_field("res_den", want.res_den, out_data.res_den);
                    check_field("is_less", want.is_less, out_data.is_less);
                    check_field("is_equal", want.is_equal, out_data.is_equal);
                    check_field("fault", want.fault, out_data.fault);
                end
            end
            if (in_valid && !in_stall)
            begin
                want = lowest_terms_result(in_data);
                awaited_results.push_back(want);
                if (want.fault)
                begin
                    fault_count++;
                end
                else if (in_data.operation == OP_CMP)
                begin
                    cmp_count++;
                end
            end
            pending = awaited_results.size();
        end
    end

endmodule

/* sim/tb_top.sv */
// testbench top for the rational fraction alu: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_top;
    import rfa_pkg::*;

    localparam int     HALF_PERIOD      = 2;
    localparam int     RESET_CYCLES     = 11;
    localparam int     RANDOM_ITEMS     = 1700;
    // long enough for the output register and the item in flight to back up
    localparam int     LONG_HOLD_CYCLES = 1500;
    // long enough to cover a slow item still in flight
    localparam int     SETTLE_CYCLES    = 300;
    localparam longint RUN_LIMIT_NS     = 20_000_000;

    // receiver behaviour for one phase
    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_RARE,
        STALL_HEAVY
    } stall_mode_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    int err_count;
    int pending;
    int result_count;
    int fault_count;
    int cmp_count;

    int burst_left;
    int sent_count;
    int directed_count;
    int hold_req_count;
    int hold_done_count;

    rational_fraction_alu u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    rfa_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .err_count    (err_count),
        .pending      (pending),
        .result_count (result_count),
        .fault_count  (fault_count),
        .cmp_count    (cmp_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    function automatic in_item_t fraction_pair(input logic [OPC_W-1:0] op, input int na,
                                               input int da, input int nb, input int db);
        in_item_t it;
        it.operation = op;
        it.num_a     = FIELD_BITS'(na);
        it.den_a     = FIELD_BITS'(da);
        it.num_b     = FIELD_BITS'(nb);
        it.den_b     = FIELD_BITS'(db);
        return it;
    endfunction

    // mix of extremes, full range and small values so that reductions actually bite
    function automatic logic [FIELD_BITS-1:0] rand_operand();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'sh8000;
                1:       return 16'sh8001;
                2:       return 16'sh7fff;
                3:       return 16'shffff;
                4:       return 16'sh0001;
                default: return 16'sh0000;
            endcase
        end
        else if (pick <= 2)
        begin
            return FIELD_BITS'($urandom);
        end
        else if (pick <= 5)
        begin
            return FIELD_BITS'(int'($urandom_range(0, 24)) - 12);
        end
        return FIELD_BITS'(int'($urandom_range(0, 800)) - 400);
    endfunction

    // mostly well-formed fractions; a few zero denominators and unused selectors
    function automatic in_item_t random_item();
        in_item_t it;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            it.operation = OPC_W'($urandom_range(OP_CMP + 1, (1 << OPC_W) - 1));
        end
        else
        begin
            it.operation = OPC_W'($urandom_range(OP_ADD, OP_CMP));
        end
        it.num_a = rand_operand();
        it.num_b = rand_operand();
        it.den_a = rand_operand();
        it.den_b = rand_operand();
        if (it.den_a == 0)
        begin
            it.den_a = 16'sd1;
        end
        if (it.den_b == 0)
        begin
            it.den_b = 16'sd1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            it.den_a = '0;
        end
        else if (roll < 4)
        begin
            it.den_b = '0;
        end
        return it;
    endfunction

    // one transfer on the input channel; a new burst starts after a random gap
    // every call begins with exactly one assignment to in_valid in this step
    task automatic offer(input in_item_t it);
        int gap;
        int roll;
        if (burst_left == 0)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                gap = $urandom_range(1, 6);
            end
            else if (roll < 95)
            begin
                gap = $urandom_range(7, 60);
            end
            else
            begin
                gap = $urandom_range(61, 300);
            end
            burst_left = $urandom_range(1, 32);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_count++;
        burst_left--;
        @(negedge clk);
    endtask

    // sender goes quiet until every awaited result has come back
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // stimulus
    initial
    begin
        in_item_t directed[$];
        int       i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        burst_left     = 0;
        sent_count     = 0;
        hold_req_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // plain sums, cancellation to zero and products at the corners
        directed.push_back(fraction_pair(OP_ADD, 1, 2, 1, 3));
        directed.push_back(fraction_pair(OP_SUB, 1, 2, 1, 2));
        directed.push_back(fraction_pair(OP_MUL, -32768, 32767, -32768, -32768));
        directed.push_back(fraction_pair(OP_DIV, 32767, -32768, -32768, 32767));
        directed.push_back(fraction_pair(OP_ADD, -32768, -32768, -32768, -32768));
        directed.push_back(fraction_pair(OP_ADD, 32767, 1, 32767, 1));
        directed.push_back(fraction_pair(OP_ADD, -32768, 1, -32768, 1));
        directed.push_back(fraction_pair(OP_SUB, 32767, -32768, -32768, 32767));
        directed.push_back(fraction_pair(OP_MUL, 0, 5, 7, 3));
        directed.push_back(fraction_pair(OP_MUL, -1, -1, -1, -1));
        directed.push_back(fraction_pair(OP_ADD, 0, -32768, 0, 32767));
        // division flipping signs and landing on the largest denominator
        directed.push_back(fraction_pair(OP_DIV, 1, -32768, -1, 32767));
        directed.push_back(fraction_pair(OP_DIV, -32768, 1, 1, -32768));
        // compares: equal values in other terms, negative denominators, near the edge
        directed.push_back(fraction_pair(OP_CMP, 1, 2, 2, 4));
        directed.push_back(fraction_pair(OP_CMP, -1, 3, 1, -4));
        directed.push_back(fraction_pair(OP_CMP, 32767, 1, -32768, -1));
        directed.push_back(fraction_pair(OP_CMP, 0, 1, 0, -5));
        directed.push_back(fraction_pair(OP_CMP, 5, 3, 1, 1));
        // faults: divide by a zero fraction, zero denominators, unused selectors
        directed.push_back(fraction_pair(OP_DIV, 3, 4, 0, 7));
        directed.push_back(fraction_pair(OP_ADD, 1, 0, 1, 2));
        directed.push_back(fraction_pair(OP_CMP, 1, 2, 1, 0));
        directed.push_back(fraction_pair(OP_CMP + 3'd1, 1, 2, 3, 4));
        directed.push_back(fraction_pair(OP_CMP + 3'd2, -7, 9, 5, -3));
        directed.push_back(fraction_pair(OP_CMP + 3'd3, 32767, -32768, -32768, 32767));
        directed_count = directed.size();

        foreach (directed[k])
        begin
            offer(directed[k]);
        end
        drain();

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                // receiver holds off while we keep pushing back to back
                hold_req_count <= hold_req_count + 1;
                burst_left = 40;
            end
            if (i == (2 * RANDOM_ITEMS) / 3)
            begin
                drain();
            end
            offer(random_item());
        end
        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("run covered %0d input transfers (%0d directed) and %0d checked results",
                 sent_count, directed_count, result_count);
        $display("including %0d faults, %0d compares and %0d long receiver hold-offs",
                 fault_count, cmp_count, hold_done_count);
        if (err_count == 0 && pending == 0)
        begin
            $display("rational_fraction_alu: match");
        end
        else
        begin
            $display("rational_fraction_alu: mismatch");
        end
        $finish;
    end

    // receiver: stall pattern changes by phase, plus the requested long hold-off
    initial
    begin
        stall_mode_t mode;
        int          phase_left;
        out_stall       = 1'b0;
        hold_done_count = 0;
        phase_left      = 0;
        mode            = STALL_NONE;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req_count != hold_done_count)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_stall       <= 1'b0;
                hold_done_count <= hold_done_count + 1;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    mode       = stall_mode_t'($urandom_range(STALL_NONE, STALL_HEAVY));
                    phase_left = $urandom_range(40, 600);
                end
                phase_left--;
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_HALF: out_stall <= ($urandom_range(0, 1) == 1);
                    STALL_RARE: out_stall <= ($urandom_range(0, 9) == 0);
                    default:    out_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // hard stop if the handshakes ever lock up
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("rational_fraction_alu: mismatch");
        $finish;
    end

endmodule
